// File: hdl/kmp_suffix_prefix_overlap_top_assert.svh
// assertion macros for the suffix/prefix overlap block
// both expect clk and arst_n in the scope where they are used
`ifndef KMP_SUFFIX_PREFIX_OVERLAP_TOP_ASSERT_SVH
`define KMP_SUFFIX_PREFIX_OVERLAP_TOP_ASSERT_SVH

// property that must hold at every edge outside reset
`define KMP_ASSERT_NOW(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

	localparam int SymW = 8;
	localparam int OutLenW = 9;

	typedef enum logic {
		KIND_PATTERN = 1'b0,
		KIND_TEXT    = 1'b1
	} kmp_kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} kmp_state_t;

	typedef struct packed {
		kmp_kind_t       kind;
		logic [SymW-1:0] symbol;
		logic            first;
		logic            last;
	} kmp_in_word_t;

	typedef struct packed {
		logic [OutLenW-1:0] overlap_length;
		logic               pattern_overflow;
	} kmp_out_word_t;

endpackage

`default_nettype wire

// File: hdl/kmp_ram.sv
`default_nettype none

// simple dual port ram, one write and one registered read per cycle
module kmp_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/kmp_suffix_prefix_overlap_top.sv
`default_nettype none

// Suffix/prefix overlap engine built on the KMP prefix function. Pattern words
// (kind = pattern) come first: each is stored and its failure-table entry is
// computed on the fly; first = 1 starts a new pattern and clears the overflow
// flag and the match length. Up to MAX_PATTERN characters are kept, further
// pattern characters are dropped and pattern_overflow is raised until the next
// pattern start. Text words (kind = text) then run through the matcher; first
// = 1 restarts matching from zero, and the word with last = 1 returns one
// result word holding the length of the longest text suffix that is a prefix of
// the pattern (low 9 bits) plus the overflow flag. A full match falls back
// through the failure table before the next character, so the symbol byte
// carries no in-band separator. Timing: one word at a time; a word is accepted,
// then compared, with a further compare for every failure-table fallback, and
// the fallbacks average out to at most about one per character over a string;
// a dropped pattern character is accepted without a compare. The pace is set
// by the compare/fallback loop around the registered read of the pattern and
// failure memories. The memories need no clearing after reset: only entries
// below the current pattern length are ever used. A result may wait on
// result_ready while the next word is accepted; the last text word after it
// stalls until the result register frees up.
module kmp_suffix_prefix_overlap_top
	import kmp_pkg::*;
#(
	parameter int MAX_PATTERN = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire kmp_in_word_t  item,
	output logic               result_valid,
	input  wire logic          result_ready,
	output kmp_out_word_t      result
);

	localparam int AW = $clog2(MAX_PATTERN);      // memory address width
	localparam int LW = $clog2(MAX_PATTERN + 1);  // lengths up to MAX_PATTERN
	localparam logic [LW-1:0] LenMax = LW'(MAX_PATTERN);

	// control state
	kmp_state_t    state_q, state_d;
	logic [LW-1:0] len_q, len_d;             // stored pattern length
	logic [LW-1:0] match_q, match_d;         // current text match length
	logic          ovf_q, ovf_d;             // pattern overflow flag
	logic [AW-1:0] last_fail_q, last_fail_d; // failure entry of last pattern char

	// word being worked on
	kmp_kind_t     kind_q;
	logic [7:0]    sym_q;
	logic          last_q;
	logic [LW-1:0] j_q, j_d;                 // candidate prefix length
	logic          load_item;

	// memory access
	logic          rd_en;
	logic [LW-1:0] rd_j;
	logic [AW-1:0] pat_raddr, fail_raddr;
	logic [7:0]    pat_rd;
	logic [AW-1:0] fail_rd;
	logic          we;

	// search helpers
	logic          hit;
	logic [LW-1:0] len_eff, j_clamp, j_start, j_fin;
	logic [LW+OutLenW-1:0] j_fin_ext;
	logic          res_load;

	assign item_ready = (state_q == ST_IDLE);

	// pattern byte at j and failure entry at j-1 are fetched together
	assign pat_raddr  = rd_j[AW-1:0];
	assign fail_raddr = AW'(rd_j[AW-1:0] - 1'b1);

	kmp_ram #(
		.Width(8),
		.Depth(MAX_PATTERN)
	) u_pat_ram (
		.clk  (clk),
		.we   (we),
		.waddr(len_q[AW-1:0]),
		.wdata(sym_q),
		.re   (rd_en),
		.raddr(pat_raddr),
		.rdata(pat_rd)
	);

	kmp_ram #(
		.Width(AW),
		.Depth(MAX_PATTERN)
	) u_fail_ram (
		.clk  (clk),
		.we   (we),
		.waddr(len_q[AW-1:0]),
		.wdata(j_fin[AW-1:0]),
		.re   (rd_en),
		.raddr(fail_raddr),
		.rdata(fail_rd)
	);

	always_comb begin
		state_d     = state_q;
		len_d       = len_q;
		match_d     = match_q;
		ovf_d       = ovf_q;
		last_fail_d = last_fail_q;
		j_d         = j_q;
		load_item   = 1'b0;
		rd_en       = 1'b0;
		rd_j        = j_q;
		we          = 1'b0;
		res_load    = 1'b0;
		len_eff     = '0;
		j_clamp     = '0;
		j_start     = '0;
		hit         = (pat_rd == sym_q);
		j_fin       = (hit && (j_q < len_q)) ? LW'(j_q + 1'b1) : j_q;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					load_item = 1'b1;
					if (item.kind == KIND_PATTERN) begin
						len_eff = item.first ? '0 : len_q;
						if (item.first) begin
							len_d   = '0;
							match_d = '0;
							ovf_d   = 1'b0;
						end
						if (len_eff == LenMax) begin
							// store full: drop the character
							ovf_d = 1'b1;
						end else begin
							j_start = (len_eff == '0) ? '0 : LW'(last_fail_q);
							rd_en   = 1'b1;
							rd_j    = j_start;
							j_d     = j_start;
							state_d = ST_SEARCH;
						end
					end else begin
						j_clamp = item.first ? '0 : match_q;
						if (j_clamp > len_q) begin
							j_clamp = len_q;
						end
						// full match: fall back once as if a separator followed
						j_start = ((j_clamp != '0) && (j_clamp == len_q)) ?
							LW'(last_fail_q) : j_clamp;
						rd_en   = 1'b1;
						rd_j    = j_start;
						j_d     = j_start;
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (hit || (j_q == '0)) begin
					if (kind_q == KIND_PATTERN) begin
						we          = 1'b1;
						last_fail_d = j_fin[AW-1:0];
						len_d       = LW'(len_q + 1'b1);
						state_d     = ST_IDLE;
					end else if (!(last_q && result_valid && !result_ready)) begin
						match_d  = j_fin;
						res_load = last_q;
						state_d  = ST_IDLE;
					end
				end else begin
					// mismatch: follow the failure link
					j_d   = LW'(fail_rd);
					rd_en = 1'b1;
					rd_j  = LW'(fail_rd);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign j_fin_ext = {{OutLenW{1'b0}}, j_fin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			match_q      <= '0;
			ovf_q        <= 1'b0;
			last_fail_q  <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			match_q     <= match_d;
			ovf_q       <= ovf_d;
			last_fail_q <= last_fail_d;
			if (res_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_item) begin
			kind_q <= item.kind;
			sym_q  <= item.symbol;
			last_q <= item.last;
		end
		j_q <= j_d;
		if (res_load) begin
			result.overlap_length   <= j_fin_ext[OutLenW-1:0];
			result.pattern_overflow <= ovf_q;
		end
	end

endmodule

`default_nettype wire

// File: hdl/kmp_chk.sv
`default_nettype none

`include "kmp_suffix_prefix_overlap_top_assert.svh"

module kmp_chk
	import kmp_pkg::*;
(
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          item_valid,
	input wire logic          item_ready,
	input wire kmp_in_word_t  item,
	input wire logic          result_valid,
	input wire logic          result_ready,
	input wire kmp_out_word_t result
);

	// a stalled result word holds
	`KMP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result word changed while stalled")

	// a text word always goes through the compare (search) state
	`KMP_ASSERT_NEXT(a_text_busy, item_valid && item_ready && (item.kind == KIND_TEXT), !item_ready, "text word accepted without a compare cycle")

	// results come only out of a search in progress
	`KMP_ASSERT_NOW(a_result_from_search, $rose(result_valid) |-> !$past(item_ready), "result raised while idle")

endmodule

bind kmp_suffix_prefix_overlap_top kmp_chk u_kmp_chk (.*);

`default_nettype wire
